@@ sv/etc_pkg.sv @@
// Shared types, constants and the strip-to-paddle lookup for the event trigger.
`timescale 1ns / 1ps

package etc_pkg;

    // Geometry
    localparam int SECTORS       = 6;
    localparam int STRIP_ENTRIES = 68;
    localparam int PADDLE_BITS   = 64;
    localparam int SUPERLAYERS   = 6;
    localparam int TABLE_LEN     = 68;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int SECTOR_W = 3;
    localparam int SL_W     = 3;
    localparam int LAYER_W  = 4;
    localparam int ENERGY_W = 16;
    localparam int STRIP_W  = 7;
    localparam int PADDLE_W = 6;
    localparam int SLTHR_W  = 3;
    localparam int DIST_W   = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [SLTHR_W-1:0]  SL_THR_RESET     = 3'd5;
    localparam logic [DIST_W-1:0]   DIST_RESET       = 6'd4;
    localparam logic [ENERGY_W-1:0] ENERGY_THR_RESET = 16'd100;

    // Calorimeter layers that count for energy
    localparam logic [LAYER_W-1:0] CAL_LAYER_MIN = 4'd1;
    localparam logic [LAYER_W-1:0] CAL_LAYER_MAX = 4'd3;

    // Item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_TRACK   = 2'd0,
        CMD_CLUSTER = 2'd1,
        CMD_PADDLE  = 2'd2,
        CMD_END     = 2'd3
    } cmd_code_t;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SL_THR     = 2'd0,
        REG_DIST       = 2'd1,
        REG_ENERGY_THR = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } ctl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_hit;
        logic start_scan;
        logic scan_step;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_sts_t;

    // Strip id minus one to paddle id minus one
    localparam logic [5:0] STRIP_TO_PADDLE [TABLE_LEN] = '{
        6'd0,  6'd1,  6'd1,  6'd2,  6'd2,  6'd3,  6'd4,  6'd4,
        6'd5,  6'd6,  6'd7,  6'd7,  6'd8,  6'd9,  6'd9,  6'd10,
        6'd11, 6'd11, 6'd12, 6'd13, 6'd13, 6'd14, 6'd15, 6'd15,
        6'd16, 6'd16, 6'd17, 6'd17, 6'd18, 6'd19, 6'd19, 6'd20,
        6'd21, 6'd21, 6'd22, 6'd23, 6'd23, 6'd24, 6'd24, 6'd25,
        6'd26, 6'd26, 6'd27, 6'd28, 6'd28, 6'd29, 6'd30, 6'd30,
        6'd31, 6'd32, 6'd32, 6'd33, 6'd34, 6'd35, 6'd37, 6'd38,
        6'd39, 6'd41, 6'd42, 6'd44, 6'd45, 6'd46, 6'd48, 6'd49,
        6'd50, 6'd52, 6'd53, 6'd54
    };

endpackage

@@ sv/event_trigger_coincidence.sv @@
// Top level of the event coincidence trigger: controller plus datapath.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  s_       | s_valid / s_ready  | command, sector, superlayer, cal_layer,
//           |                    | cluster_energy, strip_id, paddle_id
//  m_       | m_valid / m_ready  | trigger_fire, sector_ok, energy_ok, match_ok
//  cfg_     | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// Hit words (tracker, cluster, paddle) are accepted back to back while idle.
// An end-of-event word starts the gap scan, which tests one paddle gap per cycle, from 0
// up to match_distance, stopping early on a hit.
// Reset restores register defaults and clears all event bitmaps at once; no sweep.
// A pending result word does not block hit words; only the next end of event waits for it.
`timescale 1ns / 1ps

module event_trigger_coincidence import etc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [CMD_W-1:0]       s_command,
    input  logic [SECTOR_W-1:0]    s_sector,
    input  logic [SL_W-1:0]        s_superlayer,
    input  logic [LAYER_W-1:0]     s_cal_layer,
    input  logic [ENERGY_W-1:0]    s_cluster_energy,
    input  logic [STRIP_W-1:0]     s_strip_id,
    input  logic [PADDLE_W-1:0]    s_paddle_id,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_trigger_fire,
    output logic                   m_sector_ok,
    output logic                   m_energy_ok,
    output logic                   m_match_ok
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencer
    etc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Bitmaps, scan and output register
    etc_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_command        (s_command),
        .s_sector         (s_sector),
        .s_superlayer     (s_superlayer),
        .s_cal_layer      (s_cal_layer),
        .s_cluster_energy (s_cluster_energy),
        .s_strip_id       (s_strip_id),
        .s_paddle_id      (s_paddle_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_trigger_fire   (m_trigger_fire),
        .m_sector_ok      (m_sector_ok),
        .m_energy_ok      (m_energy_ok),
        .m_match_ok       (m_match_ok),
        .cmd              (cmd),
        .sts              (sts)
    );

endmodule

@@ sv/etc_ctrl.sv @@
// Sequencing FSM: hit updates, paddle match scan and result hand-off.
`timescale 1ns / 1ps

module etc_ctrl import etc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [CMD_W-1:0]     s_command,
    output logic                 s_ready,
    output dp_cmd_t              cmd,
    input  dp_sts_t              sts
);

    ctl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (cmd_code_t'(s_command) == CMD_END) begin
                        cmd.start_scan = 1'b1;
                        state_next     = ST_SCAN;
                    end else begin
                        cmd.load_hit = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the output register to drain
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/etc_datapath.sv @@
// Event bitmaps, configuration registers, paddle match scan and output register.
`timescale 1ns / 1ps

module etc_datapath import etc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input word payload
    input  logic [CMD_W-1:0]       s_command,
    input  logic [SECTOR_W-1:0]    s_sector,
    input  logic [SL_W-1:0]        s_superlayer,
    input  logic [LAYER_W-1:0]     s_cal_layer,
    input  logic [ENERGY_W-1:0]    s_cluster_energy,
    input  logic [STRIP_W-1:0]     s_strip_id,
    input  logic [PADDLE_W-1:0]    s_paddle_id,
    // result word
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_trigger_fire,
    output logic                   m_sector_ok,
    output logic                   m_energy_ok,
    output logic                   m_match_ok,
    // control
    input  dp_cmd_t                cmd,
    output dp_sts_t                sts
);

    localparam int EXP_W = STRIP_W;

    // Count of set bits in a superlayer mask
    function automatic logic [SLTHR_W-1:0] popcount_sl(input logic [SUPERLAYERS-1:0] m);
        logic [SLTHR_W-1:0] n;
        n = '0;
        for (int b = 0; b < SUPERLAYERS; b++) begin
            n = n + SLTHR_W'(m[b]);
        end
        return n;
    endfunction

    logic [SLTHR_W-1:0]     sl_thr_reg;
    logic [DIST_W-1:0]      dist_reg;
    logic [ENERGY_W-1:0]    energy_thr_reg;

    logic [SUPERLAYERS-1:0] masks_reg [SECTORS];
    logic                   energy_reg;
    logic [PADDLE_BITS-1:0] seen_reg;
    logic [PADDLE_BITS-1:0] exp_reg;

    logic [PADDLE_BITS-1:0] left_reg;
    logic [PADDLE_BITS-1:0] right_reg;
    logic [DIST_W-1:0]      count_reg;
    logic                   match_reg;

    logic                   m_valid_reg;
    logic                   fire_reg;
    logic                   sector_ok_reg;
    logic                   energy_ok_reg;
    logic                   match_ok_reg;

    logic                   cur_hit;
    logic                   sector_ok;
    logic                   strip_ok;
    logic [EXP_W-1:0]       exp_id;
    logic                   energy_hit;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sl_thr_reg     <= SL_THR_RESET;
            dist_reg       <= DIST_RESET;
            energy_thr_reg <= ENERGY_THR_RESET;
        end else if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_SL_THR:     sl_thr_reg     <= cfg_data[SLTHR_W-1:0];
                REG_DIST:       dist_reg       <= cfg_data[DIST_W-1:0];
                REG_ENERGY_THR: energy_thr_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Hit qualification
    assign energy_hit = (s_cal_layer >= CAL_LAYER_MIN) && (s_cal_layer <= CAL_LAYER_MAX)
                        && (s_cluster_energy >= energy_thr_reg);
    assign strip_ok   = (s_strip_id >= STRIP_W'(1)) && (s_strip_id <= STRIP_W'(STRIP_ENTRIES))
                        && (s_strip_id <= STRIP_W'(TABLE_LEN));
    assign exp_id     = strip_ok ? (EXP_W'(STRIP_TO_PADDLE[s_strip_id - STRIP_W'(1)]) + EXP_W'(1))
                                 : '0;

    // Any sector at or above the superlayer threshold
    always_comb begin
        sector_ok = 1'b0;
        for (int i = 0; i < SECTORS; i++) begin
            if (popcount_sl(masks_reg[i]) >= sl_thr_reg) begin
                sector_ok = 1'b1;
            end
        end
    end

    // Current gap test: seen paddle at expected +/- count
    assign cur_hit       = |(seen_reg & (left_reg | right_reg));
    assign sts.scan_last = cur_hit || (count_reg == dist_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

    // Event bitmaps
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.finish) begin
            for (int i = 0; i < SECTORS; i++) begin
                masks_reg[i] <= '0;
            end
            energy_reg <= 1'b0;
            seen_reg   <= '0;
            exp_reg    <= '0;
        end else if (cmd.load_hit) begin
            case (cmd_code_t'(s_command))
                CMD_TRACK: begin
                    for (int i = 0; i < SECTORS; i++) begin
                        for (int j = 0; j < SUPERLAYERS; j++) begin
                            if (s_sector == SECTOR_W'(i + 1) && s_superlayer == SL_W'(j + 1)) begin
                                masks_reg[i][j] <= 1'b1;
                            end
                        end
                    end
                end
                CMD_CLUSTER: begin
                    if (energy_hit) begin
                        energy_reg <= 1'b1;
                    end
                    if (strip_ok && (exp_id < EXP_W'(PADDLE_BITS))) begin
                        exp_reg <= exp_reg | (PADDLE_BITS'(1) << exp_id);
                    end
                end
                CMD_PADDLE: begin
                    if (8'(s_paddle_id) < 8'(PADDLE_BITS)) begin
                        seen_reg <= seen_reg | (PADDLE_BITS'(1) << s_paddle_id);
                    end
                end
                default: ;
            endcase
        end
    end

    // Match scan: one gap value per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            match_reg <= 1'b0;
        end else if (cmd.start_scan) begin
            count_reg <= '0;
            match_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            match_reg <= match_reg | cur_hit;
            if (!sts.scan_last) begin
                count_reg <= count_reg + DIST_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_scan) begin
            left_reg  <= exp_reg;
            right_reg <= exp_reg;
        end else if (cmd.scan_step) begin
            left_reg  <= left_reg << 1;
            right_reg <= right_reg >> 1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            fire_reg      <= sector_ok && energy_reg && match_reg;
            sector_ok_reg <= sector_ok;
            energy_ok_reg <= energy_reg;
            match_ok_reg  <= match_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_trigger_fire = fire_reg;
    assign m_sector_ok    = sector_ok_reg;
    assign m_energy_ok    = energy_ok_reg;
    assign m_match_ok     = match_ok_reg;

    // Checks
    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (seen_reg == '0) && (exp_reg == '0) && !energy_reg)
        else $error("event state not cleared after result load");

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending word");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> (count_reg <= dist_reg))
        else $error("scan ran past match distance");

    a_fire_and: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (fire_reg == (sector_ok_reg && energy_ok_reg && match_ok_reg)))
        else $error("trigger bit disagrees with condition bits");

endmodule

@@ tb/sv/tb_event_trigger_coincidence.sv @@
// Self-checking bench for the event coincidence trigger: predicted verdicts against the m_ channel.
`timescale 1ns / 1ps

import etc_pkg::*;

// One end-of-event verdict as it leaves the result channel
typedef struct packed {
    logic fire;
    logic sector_ok;
    logic energy_ok;
    logic match_ok;
} verdict_t;

// One input word, all fields
typedef struct packed {
    cmd_code_t             command;
    logic [SECTOR_W-1:0]   sector;
    logic [SL_W-1:0]       superlayer;
    logic [LAYER_W-1:0]    cal_layer;
    logic [ENERGY_W-1:0]   cluster_energy;
    logic [STRIP_W-1:0]    strip_id;
    logic [PADDLE_W-1:0]   paddle_id;
} hit_word_t;

// Keeps its own copy of the event bitmaps and registers, queues the verdicts due
class event_judge;
    logic [SLTHR_W-1:0]     sl_thr;
    logic [DIST_W-1:0]      match_dist;
    logic [ENERGY_W-1:0]    e_thr;
    logic [SUPERLAYERS-1:0] sl_mask [SECTORS];
    logic                   energy_seen;
    logic [PADDLE_BITS-1:0] paddles_seen;
    logic [PADDLE_BITS-1:0] paddles_expected;
    verdict_t               verdicts_due [$];
    int                     mismatches;

    function new();
        sl_thr     = SL_THR_RESET;
        match_dist = DIST_RESET;
        e_thr      = ENERGY_THR_RESET;
        mismatches = 0;
        clear_event();
    endfunction

    function void clear_event();
        foreach (sl_mask[i]) sl_mask[i] = '0;
        energy_seen      = 1'b0;
        paddles_seen     = '0;
        paddles_expected = '0;
    endfunction

    task report(string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        mismatches++;
    endtask

    // Register write as accepted on the cfg_ channel; unknown index is dropped
    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SL_THR:     sl_thr     = data[SLTHR_W-1:0];
            REG_DIST:       match_dist = data[DIST_W-1:0];
            REG_ENERGY_THR: e_thr      = data[ENERGY_W-1:0];
            default: ;
        endcase
    endfunction

    // Accepted input word: update the bitmaps, or judge the event on an end word
    function void take_word(hit_word_t w);
        int       pad;
        int       gap;
        verdict_t v;
        case (w.command)
            CMD_TRACK: begin
                if (w.sector >= 1 && w.sector <= SECTORS &&
                    w.superlayer >= 1 && w.superlayer <= SUPERLAYERS)
                    sl_mask[int'(w.sector) - 1][int'(w.superlayer) - 1] = 1'b1;
            end
            CMD_CLUSTER: begin
                // energy counts whatever the strip, strip marks whatever the energy
                if (w.cal_layer >= CAL_LAYER_MIN && w.cal_layer <= CAL_LAYER_MAX &&
                    w.cluster_energy >= e_thr)
                    energy_seen = 1'b1;
                if (w.strip_id >= 1 && w.strip_id <= STRIP_ENTRIES) begin
                    pad = int'(STRIP_TO_PADDLE[int'(w.strip_id) - 1]) + 1;
                    if (pad < PADDLE_BITS) paddles_expected[pad] = 1'b1;
                end
            end
            CMD_PADDLE: begin
                if (w.paddle_id < PADDLE_BITS) paddles_seen[w.paddle_id] = 1'b1;
            end
            CMD_END: begin
                v = '0;
                for (int i = 0; i < SECTORS; i++)
                    if ($countones(sl_mask[i]) >= int'(sl_thr)) v.sector_ok = 1'b1;
                v.energy_ok = energy_seen;
                for (int p = 0; p < PADDLE_BITS; p++) begin
                    if (paddles_seen[p]) begin
                        for (int e = 0; e < PADDLE_BITS; e++) begin
                            gap = (p > e) ? p - e : e - p;
                            if (paddles_expected[e] && gap <= int'(match_dist))
                                v.match_ok = 1'b1;
                        end
                    end
                end
                v.fire = v.sector_ok & v.energy_ok & v.match_ok;
                verdicts_due.push_back(v);
                clear_event();
            end
        endcase
    endfunction

    // Result word from the block against the oldest verdict due
    task check_verdict(verdict_t got);
        verdict_t want;
        if (verdicts_due.size() == 0) begin
            report($sformatf("result %b with no verdict due", got));
            return;
        end
        want = verdicts_due.pop_front();
        if (got.fire !== want.fire)
            report($sformatf("trigger_fire got %b want %b", got.fire, want.fire));
        if (got.sector_ok !== want.sector_ok)
            report($sformatf("sector_ok got %b want %b", got.sector_ok, want.sector_ok));
        if (got.energy_ok !== want.energy_ok)
            report($sformatf("energy_ok got %b want %b", got.energy_ok, want.energy_ok));
        if (got.match_ok !== want.match_ok)
            report($sformatf("match_ok got %b want %b", got.match_ok, want.match_ok));
    endtask

    task close_out();
        if (verdicts_due.size() != 0)
            report($sformatf("%0d verdicts never arrived", verdicts_due.size()));
    endtask
endclass

module tb_event_trigger_coincidence;

    localparam int SETTLE_CYCLES = 80;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 62;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_command;
    logic [SECTOR_W-1:0]   s_sector;
    logic [SL_W-1:0]       s_superlayer;
    logic [LAYER_W-1:0]    s_cal_layer;
    logic [ENERGY_W-1:0]   s_cluster_energy;
    logic [STRIP_W-1:0]    s_strip_id;
    logic [PADDLE_W-1:0]   s_paddle_id;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_trigger_fire;
    logic                  m_sector_ok;
    logic                  m_energy_ok;
    logic                  m_match_ok;

    event_judge judge;
    int         burst_left;

    event_trigger_coincidence dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_sector         (s_sector),
        .s_superlayer     (s_superlayer),
        .s_cal_layer      (s_cal_layer),
        .s_cluster_energy (s_cluster_energy),
        .s_strip_id       (s_strip_id),
        .s_paddle_id      (s_paddle_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_trigger_fire   (m_trigger_fire),
        .m_sector_ok      (m_sector_ok),
        .m_energy_ok      (m_energy_ok),
        .m_match_ok       (m_match_ok)
    );

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: switches between randomly chosen stall modes
    initial begin
        int mode;
        int hold;
        m_ready <= 1'b0;
        mode = 0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold == 0) begin
                mode = $urandom_range(0, 3);
                hold = $urandom_range(40, 200);
            end
            hold--;
            case (mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 1) == 1);
                2:       m_ready <= ($urandom_range(0, 7) == 0);
                default: m_ready <= hold[2];
            endcase
        end
    end

    // Result monitor, sampled at the edge
    always @(posedge aclk) begin : result_monitor
        verdict_t got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_trigger_fire, m_sector_ok, m_energy_ok, m_match_ok};
            judge.check_verdict(got);
        end
    end

    function automatic hit_word_t random_word();
        hit_word_t w;
        w.command        = cmd_code_t'($urandom_range(0, 3));
        w.sector         = SECTOR_W'($urandom_range(0, 7));
        w.superlayer     = SL_W'($urandom_range(0, 7));
        w.cal_layer      = LAYER_W'($urandom_range(0, 15));
        w.cluster_energy = ENERGY_W'($urandom_range(0, 65535));
        w.strip_id       = STRIP_W'($urandom_range(0, 127));
        w.paddle_id      = PADDLE_W'($urandom_range(0, 63));
        return w;
    endfunction

    function automatic hit_word_t make_word(cmd_code_t c, int sec, int sl, int lay,
                                            int en, int strip, int pad);
        hit_word_t w;
        w.command        = c;
        w.sector         = SECTOR_W'(sec);
        w.superlayer     = SL_W'(sl);
        w.cal_layer      = LAYER_W'(lay);
        w.cluster_energy = ENERGY_W'(en);
        w.strip_id       = STRIP_W'(strip);
        w.paddle_id      = PADDLE_W'(pad);
        return w;
    endfunction

    // Sender: bursts of words with random gaps between them
    task automatic send_word(hit_word_t w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        s_valid          <= 1'b1;
        s_command        <= w.command;
        s_sector         <= w.sector;
        s_superlayer     <= w.superlayer;
        s_cal_layer      <= w.cal_layer;
        s_cluster_energy <= w.cluster_energy;
        s_strip_id       <= w.strip_id;
        s_paddle_id      <= w.paddle_id;
        do @(posedge aclk); while (!s_ready);
        judge.take_word(w);
    endtask

    // Wait for every verdict, then let any trailing hit word settle
    task automatic drain();
        s_valid <= 1'b0;
        while (judge.verdicts_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        burst_left = 0;
    endtask

    // All registers in one go; unused bits and the spare index carry noise
    task automatic write_settings(int thr, int gap_max, int ethr);
        reg_idx_t              idx [4];
        logic [CFG_DATA_W-1:0] data [4];
        idx     = '{REG_SL_THR, REG_DIST, REG_ENERGY_THR, REG_UNUSED};
        data[0] = CFG_DATA_W'($urandom());
        data[0][SLTHR_W-1:0] = thr[SLTHR_W-1:0];
        data[1] = CFG_DATA_W'($urandom());
        data[1][DIST_W-1:0] = gap_max[DIST_W-1:0];
        data[2] = ethr[CFG_DATA_W-1:0];
        data[3] = CFG_DATA_W'($urandom());
        for (int k = 0; k < 4; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= data[k];
            do @(posedge aclk); while (!cfg_ready);
            judge.set_reg(idx[k], data[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Hand-picked events at the reset settings (threshold 5, distance 4, energy 100)
    task automatic directed_words();
        // full coincidence at the edge of every threshold
        for (int sl = 1; sl <= 5; sl++) send_word(make_word(CMD_TRACK, 1, sl, 0, 0, 0, 0));
        send_word(make_word(CMD_CLUSTER, 0, 0, 1, 100, 1, 0));
        send_word(make_word(CMD_PADDLE, 0, 0, 0, 0, 0, 5));
        send_word(make_word(CMD_END, 0, 0, 0, 0, 0, 0));
        // empty event
        send_word(make_word(CMD_END, 7, 7, 15, 65535, 127, 63));
        // out-of-range tracker ids
        send_word(make_word(CMD_TRACK, 0, 1, 0, 0, 0, 0));
        send_word(make_word(CMD_TRACK, 7, 2, 0, 0, 0, 0));
        send_word(make_word(CMD_TRACK, 6, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_TRACK, 6, 7, 0, 0, 0, 0));
        for (int sl = 2; sl <= 6; sl++) send_word(make_word(CMD_TRACK, 6, sl, 0, 0, 0, 0));
        // clusters outside the energy layers, below threshold, bad strips, last strip
        send_word(make_word(CMD_CLUSTER, 0, 0, 0, 65535, 0, 0));
        send_word(make_word(CMD_CLUSTER, 0, 0, 4, 65535, 127, 0));
        send_word(make_word(CMD_CLUSTER, 0, 0, 3, 99, 69, 0));
        send_word(make_word(CMD_CLUSTER, 0, 0, 15, 0, 68, 0));
        send_word(make_word(CMD_PADDLE, 0, 0, 0, 0, 0, 63));
        send_word(make_word(CMD_END, 0, 0, 0, 0, 0, 0));
        // bad strip still counts for energy; match exactly at the distance
        send_word(make_word(CMD_CLUSTER, 0, 0, 3, 65535, 0, 0));
        send_word(make_word(CMD_PADDLE, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_CLUSTER, 0, 0, 2, 100, 68, 0));
        send_word(make_word(CMD_PADDLE, 0, 0, 0, 0, 0, 59));
        send_word(make_word(CMD_END, 0, 0, 0, 0, 0, 0));
    endtask

    // One event of random hits biased towards coincidences, closed by an end word
    task automatic random_event(bit noisy, output int counted);
        int        hits;
        int        focus;
        int        kind;
        int        near_pad;
        int        span;
        int        t;
        hit_word_t w;
        counted  = 0;
        hits     = ($urandom_range(0, 2) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 12);
        focus    = $urandom_range(1, SECTORS);
        near_pad = $urandom_range(1, 55);
        span     = (int'(judge.match_dist) + 2 > 10) ? 10 : int'(judge.match_dist) + 2;
        repeat (hits) begin
            w    = random_word();
            kind = $urandom_range(0, 99);
            if (noisy && kind < 25) begin
                // raw noise, any command
                send_word(w);
            end else begin
                if (kind < 50) begin
                    w.command = CMD_TRACK;
                    if ($urandom_range(0, 9) < 7) w.sector = SECTOR_W'(focus);
                    if ($urandom_range(0, 9) < 9)
                        w.superlayer = SL_W'($urandom_range(1, SUPERLAYERS));
                end else if (kind < 75) begin
                    w.command = CMD_CLUSTER;
                    if ($urandom_range(0, 9) < 6) w.cal_layer = LAYER_W'($urandom_range(1, 3));
                    if ($urandom_range(0, 9) < 4) begin
                        t = int'(judge.e_thr) + int'($urandom_range(0, 4)) - 2;
                        if (t < 0) t = 0;
                        if (t > 65535) t = 65535;
                        w.cluster_energy = ENERGY_W'(t);
                    end
                    if ($urandom_range(0, 9) < 8) begin
                        w.strip_id = STRIP_W'($urandom_range(1, STRIP_ENTRIES));
                        near_pad   = int'(STRIP_TO_PADDLE[int'(w.strip_id) - 1]) + 1;
                    end
                end else begin
                    w.command = CMD_PADDLE;
                    if ($urandom_range(0, 1) == 1) begin
                        t = near_pad + int'($urandom_range(0, 2 * span)) - span;
                        if (t < 0) t = 0;
                        if (t > 63) t = 63;
                        w.paddle_id = PADDLE_W'(t);
                    end
                end
                send_word(w);
                counted++;
            end
        end
        w         = random_word();
        w.command = CMD_END;
        send_word(w);
        counted++;
    endtask

    // Main sequence
    initial begin
        int words;
        int got;
        judge            = new();
        burst_left       = 0;
        aresetn          <= 1'b0;
        cfg_valid        <= 1'b0;
        cfg_index        <= REG_SL_THR;
        cfg_data         <= '0;
        s_valid          <= 1'b0;
        s_command        <= CMD_TRACK;
        s_sector         <= '0;
        s_superlayer     <= '0;
        s_cal_layer      <= '0;
        s_cluster_energy <= '0;
        s_strip_id       <= '0;
        s_paddle_id      <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_words();
        drain();

        for (int ph = 1; ph <= PHASES; ph++) begin
            case (ph)
                1:       write_settings(0, 0, 0);
                2:       write_settings(7, 63, 65535);
                3:       write_settings(6, 63, 0);
                4:       write_settings(1, 1, 1);
                default: write_settings($urandom_range(0, 7), $urandom_range(0, 8),
                                        $urandom_range(0, 400));
            endcase
            // empty event first: shows the zero and unreachable thresholds
            send_word(make_word(CMD_END, 0, 0, 0, 0, 0, 0));
            words = 0;
            while (words < PHASE_WORDS) begin
                random_event($urandom_range(0, 3) == 0, got);
                words += got;
            end
            drain();
        end

        judge.close_out();
        if (judge.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
